// ----- design/srtf_pkg.sv -----
// Shared types and constants for the shortest-remaining-time scheduler.
package srtf_pkg;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned SLOT_W = 4;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    time_t arrival;
    time_t remaining;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } state_t;

endpackage

// ----- design/srtf_cmd_if.sv -----
// Command and result channel interfaces for the scheduler.
interface srtf_cmd_if;
  import srtf_pkg::*;
  logic  valid;
  logic  ready;
  op_t   operation;
  slot_t slot;
  time_t arrival_time;
  time_t service_time;
  modport source (output valid, operation, slot, arrival_time, service_time, input ready);
  modport sink (input valid, operation, slot, arrival_time, service_time, output ready);
endinterface

interface srtf_res_if;
  import srtf_pkg::*;
  logic  valid;
  logic  ready;
  time_t tick_time;
  slot_t chosen_slot;
  logic  idle;
  logic  finished;
  modport source (output valid, tick_time, chosen_slot, idle, finished, input ready);
  modport sink (input valid, tick_time, chosen_slot, idle, finished, output ready);
endinterface

// ----- design/srtf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srtf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/shortest_remaining_time_scheduler.sv -----
// Top level: preemptive shortest-remaining-time scheduler over a slot table.
//
//   channel  dir  transfer moves                                        results
//   cmd      in   operation, slot, arrival_time, service_time           -
//   res      out  tick_time, chosen_slot, idle, finished                1 per tick
//
// A load writes its slot directly and the block stays ready.
// After a tick transfer the block is busy: it starts the RAM read, compares one
// entry a cycle in the shared unit, then writes back. A new tick is taken only
// once the last one has finished and loaded its result into the result register.
// The result register holds until taken; a tick waits at its end while it is full.
// Reset empties all slots at once through per-slot valid bits and zeroes time.
module shortest_remaining_time_scheduler #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input logic        clk,
  input logic        rst,
  srtf_cmd_if.sink   cmd,
  srtf_res_if.source res
);
  import srtf_pkg::*;

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  state_t state, state_next;

  logic [NUM_SLOTS-1:0] vld;
  time_t   cur_time;
  logic [IW-1:0] idx;
  logic [IW-1:0] cmp_idx;
  logic          found;
  logic [IW-1:0] best_idx;
  entry_t        best;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_raw;
  entry_t        rd_ent;

  logic cmd_xfer;
  logic load_xfer;
  logic load_hit;
  logic tick_xfer;
  logic out_free;
  logic do_cmp;
  logic eligible;
  logic finish;

  srtf_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx),
    .rd_data (rd_raw)
  );

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign load_xfer = cmd_xfer && (cmd.operation == OP_LOAD);
  assign tick_xfer = cmd_xfer && (cmd.operation == OP_TICK);
  assign load_hit  = load_xfer && (32'(cmd.slot) < NUM_SLOTS);
  assign out_free  = !res.valid || res.ready;
  assign finish    = (state == ST_UPDATE) && out_free;

  assign do_cmp   = (state == ST_LAST) || ((state == ST_SCAN) && (idx != '0));
  assign rd_ent   = vld[cmp_idx] ? rd_raw : '0;
  assign eligible = (rd_ent.remaining != '0) && (rd_ent.arrival <= cur_time);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IW'(cmd.slot);
    wr_data = '{arrival: cmd.arrival_time, remaining: cmd.service_time};
    if (load_hit) begin
      wr_en = 1'b1;
    end else if (finish && found) begin
      wr_en   = 1'b1;
      wr_addr = best_idx;
      wr_data = '{arrival: best.arrival, remaining: best.remaining - 1'b1};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (tick_xfer) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx == IW'(NUM_SLOTS - 1)) state_next = ST_LAST;
      end
      ST_LAST: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vld       <= '0;
      cur_time  <= '0;
      res.valid <= 1'b0;
      idx       <= '0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      if (load_hit) begin
        vld[IW'(cmd.slot)] <= 1'b1;
      end
      if (tick_xfer) begin
        idx   <= '0;
        found <= 1'b0;
      end
      if (state == ST_SCAN && idx != IW'(NUM_SLOTS - 1)) begin
        idx <= idx + 1'b1;
      end
      if (do_cmp && eligible && (!found || rd_ent.remaining < best.remaining)) begin
        found <= 1'b1;
      end
      if (finish) begin
        res.valid <= 1'b1;
        cur_time  <= cur_time + 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      cmp_idx <= idx;
    end
    if (do_cmp && eligible && (!found || rd_ent.remaining < best.remaining)) begin
      best     <= rd_ent;
      best_idx <= cmp_idx;
    end
    if (finish) begin
      res.tick_time   <= cur_time;
      res.chosen_slot <= found ? SLOT_W'(best_idx) : '0;
      res.idle        <= !found;
      res.finished    <= found && (best.remaining == time_t'(1));
    end
  end

endmodule
